>>> rtl/core/ppbh_pkg.sv
// Shared types, sizes and microcode for the point plot bitmap hex raster block.
// Depends on nothing; every other file of the block refers to it by scoped names.

package ppbh_pkg;

    // Largest image the bitmap store can hold.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Bytes per bitmap row and the resulting store geometry.
    localparam int STRIDE = (MAX_WIDTH + 7) / 8;
    localparam int DEPTH  = MAX_HEIGHT * STRIDE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int BC_W   = (STRIDE > 1) ? $clog2(STRIDE) : 1;

    // Width of a saturated image size; holds both a 12-bit register and a size of 4096.
    localparam int SZ_W = 13;

    // Configuration register indexes.
    localparam logic [2:0] CFG_X_ORIGIN  = 3'd0;
    localparam logic [2:0] CFG_Y_ORIGIN  = 3'd1;
    localparam logic [2:0] CFG_X_GAIN    = 3'd2;
    localparam logic [2:0] CFG_Y_GAIN    = 3'd3;
    localparam logic [2:0] CFG_WIDTH_PX  = 3'd4;
    localparam logic [2:0] CFG_HEIGHT_PX = 3'd5;
    localparam logic [2:0] CFG_DOT_SIZE  = 3'd6;

    // Dot pattern codes.
    localparam logic [1:0] DOT_SINGLE = 2'd0;
    localparam logic [1:0] DOT_VPAIR  = 2'd1;
    localparam logic [1:0] DOT_2X2    = 2'd2;
    localparam logic [1:0] DOT_3X3    = 2'd3;

    // Configuration register file contents.
    typedef struct packed {
        logic signed [31:0] x_origin;
        logic signed [31:0] y_origin;
        logic [31:0]        x_gain;
        logic [31:0]        y_gain;
        logic [11:0]        width_px;
        logic [11:0]        height_px;
        logic [1:0]         dot_size;
    } cfg_t;

    // Datapath operations selected by a control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_IDLE,
        OP_DIFF_X,
        OP_MUL_X,
        OP_SIGN_X,
        OP_DIFF_Y,
        OP_MUL_Y,
        OP_SIGN_Y,
        OP_PIX_RD,
        OP_PIX_WR,
        OP_RD_FIX,
        OP_RD_MEM,
        OP_RD_OUT
    } op_t;

    // Pixel offset relative to the scaled point.
    typedef enum logic [1:0] {
        OFF_Z,
        OFF_M1,
        OFF_P1
    } off_t;

    // Sequencer jump conditions.
    typedef enum logic [2:0] {
        J_NEXT,
        J_CLR,
        J_START,
        J_DOT,
        J_END
    } jmp_t;

    // One microcode control word.
    typedef struct packed {
        op_t  op;
        off_t off_x;
        off_t off_y;
        jmp_t jmp;
    } ctrl_t;

    // Program counter and the entry points of the microprogram.
    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_CLEAR = 6'd0;
    localparam logic [PC_W-1:0] PC_IDLE  = 6'd1;
    localparam logic [PC_W-1:0] PC_DOT0  = 6'd8;
    localparam logic [PC_W-1:0] PC_DOT1  = 6'd10;
    localparam logic [PC_W-1:0] PC_DOT2  = 6'd14;
    localparam logic [PC_W-1:0] PC_DOT3  = 6'd22;
    localparam logic [PC_W-1:0] PC_READ  = 6'd40;

    // Builds one control word.
    function automatic ctrl_t cw(input op_t op, input off_t ox, input off_t oy,
                                 input jmp_t j);
        ctrl_t c;
        c.op    = op;
        c.off_x = ox;
        c.off_y = oy;
        c.jmp   = j;
        return c;
    endfunction

    // The microprogram. Each pixel takes a read step and a write step.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        unique case (pc)
            // Clearing pass after reset, then wait for a transaction.
            6'd0:  c = cw(OP_CLEAR,  OFF_Z,  OFF_Z,  J_CLR);
            6'd1:  c = cw(OP_IDLE,   OFF_Z,  OFF_Z,  J_START);
            // Scale the point on both axes with the shared multiplier.
            6'd2:  c = cw(OP_DIFF_X, OFF_Z,  OFF_Z,  J_NEXT);
            6'd3:  c = cw(OP_MUL_X,  OFF_Z,  OFF_Z,  J_NEXT);
            6'd4:  c = cw(OP_SIGN_X, OFF_Z,  OFF_Z,  J_NEXT);
            6'd5:  c = cw(OP_DIFF_Y, OFF_Z,  OFF_Z,  J_NEXT);
            6'd6:  c = cw(OP_MUL_Y,  OFF_Z,  OFF_Z,  J_NEXT);
            6'd7:  c = cw(OP_SIGN_Y, OFF_Z,  OFF_Z,  J_DOT);
            // Single dot.
            6'd8:  c = cw(OP_PIX_RD, OFF_Z,  OFF_Z,  J_NEXT);
            6'd9:  c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_END);
            // Two vertical dots.
            6'd10: c = cw(OP_PIX_RD, OFF_Z,  OFF_Z,  J_NEXT);
            6'd11: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd12: c = cw(OP_PIX_RD, OFF_Z,  OFF_M1, J_NEXT);
            6'd13: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_END);
            // Two by two.
            6'd14: c = cw(OP_PIX_RD, OFF_Z,  OFF_Z,  J_NEXT);
            6'd15: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd16: c = cw(OP_PIX_RD, OFF_P1, OFF_Z,  J_NEXT);
            6'd17: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd18: c = cw(OP_PIX_RD, OFF_Z,  OFF_P1, J_NEXT);
            6'd19: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd20: c = cw(OP_PIX_RD, OFF_P1, OFF_P1, J_NEXT);
            6'd21: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_END);
            // Three by three.
            6'd22: c = cw(OP_PIX_RD, OFF_M1, OFF_M1, J_NEXT);
            6'd23: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd24: c = cw(OP_PIX_RD, OFF_Z,  OFF_M1, J_NEXT);
            6'd25: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd26: c = cw(OP_PIX_RD, OFF_P1, OFF_M1, J_NEXT);
            6'd27: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd28: c = cw(OP_PIX_RD, OFF_M1, OFF_Z,  J_NEXT);
            6'd29: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd30: c = cw(OP_PIX_RD, OFF_Z,  OFF_Z,  J_NEXT);
            6'd31: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd32: c = cw(OP_PIX_RD, OFF_P1, OFF_Z,  J_NEXT);
            6'd33: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd34: c = cw(OP_PIX_RD, OFF_M1, OFF_P1, J_NEXT);
            6'd35: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd36: c = cw(OP_PIX_RD, OFF_Z,  OFF_P1, J_NEXT);
            6'd37: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_NEXT);
            6'd38: c = cw(OP_PIX_RD, OFF_P1, OFF_P1, J_NEXT);
            6'd39: c = cw(OP_PIX_WR, OFF_Z,  OFF_Z,  J_END);
            // Raster byte read.
            6'd40: c = cw(OP_RD_FIX, OFF_Z,  OFF_Z,  J_NEXT);
            6'd41: c = cw(OP_RD_MEM, OFF_Z,  OFF_Z,  J_NEXT);
            6'd42: c = cw(OP_RD_OUT, OFF_Z,  OFF_Z,  J_END);
            default: c = cw(OP_NOP,  OFF_Z,  OFF_Z,  J_END);
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/ppbh_sequencer.sv
// Microcode sequencer: program counter, control store lookup and jump logic.
// Depends on ppbh_pkg for the control word type and the microprogram.

module ppbh_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              action,
    input  logic [1:0]        dot_size,
    input  logic              clr_done,
    output ppbh_pkg::ctrl_t   ctrl,
    output logic              busy
);

    logic [ppbh_pkg::PC_W-1:0] pc_reg;
    logic [ppbh_pkg::PC_W-1:0] pc_next;

    // Control word of the current step comes straight from the control store.
    assign ctrl = ppbh_pkg::ucode(pc_reg);
    assign busy = (pc_reg != ppbh_pkg::PC_IDLE);

    // Next step from the jump condition of the current control word.
    always_comb
    begin
        unique case (ctrl.jmp)
            ppbh_pkg::J_NEXT:  pc_next = pc_reg + 1'b1;
            ppbh_pkg::J_CLR:   pc_next = clr_done ? pc_reg + 1'b1 : pc_reg;
            ppbh_pkg::J_START:
            begin
                if (!start)
                    pc_next = pc_reg;
                else if (action)
                    pc_next = ppbh_pkg::PC_READ;
                else
                    pc_next = pc_reg + 1'b1;
            end
            ppbh_pkg::J_DOT:
            begin
                unique case (dot_size)
                    ppbh_pkg::DOT_SINGLE: pc_next = ppbh_pkg::PC_DOT0;
                    ppbh_pkg::DOT_VPAIR:  pc_next = ppbh_pkg::PC_DOT1;
                    ppbh_pkg::DOT_2X2:    pc_next = ppbh_pkg::PC_DOT2;
                    default:              pc_next = ppbh_pkg::PC_DOT3;
                endcase
            end
            default:           pc_next = ppbh_pkg::PC_IDLE;
        endcase
    end

    // Step counter; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= ppbh_pkg::PC_CLEAR;
        else
            pc_reg <= pc_next;
    end

endmodule

>>> rtl/core/ppbh_datapath.sv
// Datapath: point scaling, dot pixel read-modify-write, bitmap memory and hex read-out.
// Depends on ppbh_pkg for sizes, the configuration struct and the control word.

module ppbh_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ppbh_pkg::ctrl_t     ctrl,
    input  logic                start,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    input  ppbh_pkg::cfg_t      cfg,
    output logic                clr_done,
    output logic [6:0]          hex_high,
    output logic [6:0]          hex_low,
    output logic                end_of_row,
    output logic                end_of_image,
    output logic                done
);

    // Bitmap store, bit 7 of a byte is the leftmost pixel.
    logic [7:0] mem [ppbh_pkg::DEPTH];

    // Control state.
    logic [ppbh_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic [ppbh_pkg::ROW_W-1:0]  rrow_reg;
    logic [ppbh_pkg::BC_W-1:0]   rcol_reg;
    logic                        done_reg;

    // Payload registers.
    logic signed [31:0]          x_reg;
    logic signed [31:0]          y_reg;
    logic [31:0]                 mag_reg;
    logic                        neg_reg;
    logic [31:0]                 prod_reg;
    logic signed [33:0]          ix_reg;
    logic signed [33:0]          iy_reg;
    logic [ppbh_pkg::ADDR_W-1:0] addr_reg;
    logic [7:0]                  mask_reg;
    logic                        hit_reg;
    logic [7:0]                  rd_reg;
    logic [6:0]                  hex_high_reg;
    logic [6:0]                  hex_low_reg;
    logic                        eor_reg;
    logic                        eoi_reg;

    // Combinational signals.
    logic [ppbh_pkg::SZ_W-1:0]   w_eff;
    logic [ppbh_pkg::SZ_W-1:0]   h_eff;
    logic [ppbh_pkg::BC_W:0]     cols;
    logic signed [31:0]          diff_a;
    logic signed [31:0]          diff_o;
    logic [32:0]                 diff;
    logic [32:0]                 diff_abs;
    logic [31:0]                 gain_sel;
    logic [63:0]                 product;
    logic signed [33:0]          sidx;
    logic signed [33:0]          px;
    logic signed [33:0]          py;
    logic                        in_x;
    logic                        in_y;
    logic [ppbh_pkg::ADDR_W-1:0] pix_addr;
    logic                        col_over;
    logic [ppbh_pkg::ROW_W:0]    row_inc;
    logic [ppbh_pkg::ROW_W-1:0]  fix_row;
    logic [ppbh_pkg::BC_W-1:0]   fix_col;
    logic [ppbh_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                  inv;
    logic                        eor;
    logic                        eoi;
    logic [ppbh_pkg::BC_W:0]     col_adv;
    logic                        col_wrap;
    logic [ppbh_pkg::ROW_W:0]    row_adv;
    logic [ppbh_pkg::ROW_W-1:0]  adv_row;
    logic [ppbh_pkg::BC_W-1:0]   adv_col;
    logic                        mem_we;
    logic [ppbh_pkg::ADDR_W-1:0] mem_waddr;
    logic [7:0]                  mem_wdata;
    logic                        mem_re;
    logic [ppbh_pkg::ADDR_W-1:0] mem_raddr;

    // Lowercase ASCII hex digit of a nibble.
    function automatic logic [6:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
            return 7'h30 + 7'(n);
        else
            return 7'h61 + 7'(n - 4'd10);
    endfunction

    // Offset of a dot pixel from the scaled point.
    function automatic logic signed [33:0] offset_value(input ppbh_pkg::off_t o);
        unique case (o)
            ppbh_pkg::OFF_M1: return -34'sd1;
            ppbh_pkg::OFF_P1: return 34'sd1;
            default:          return 34'sd0;
        endcase
    endfunction

    // Image size saturated to the store limits, and bytes per row.
    always_comb
    begin
        if (cfg.width_px == '0)
            w_eff = ppbh_pkg::SZ_W'(1);
        else if (ppbh_pkg::SZ_W'(cfg.width_px) > ppbh_pkg::SZ_W'(ppbh_pkg::MAX_WIDTH))
            w_eff = ppbh_pkg::SZ_W'(ppbh_pkg::MAX_WIDTH);
        else
            w_eff = ppbh_pkg::SZ_W'(cfg.width_px);

        if (cfg.height_px == '0)
            h_eff = ppbh_pkg::SZ_W'(1);
        else if (ppbh_pkg::SZ_W'(cfg.height_px) > ppbh_pkg::SZ_W'(ppbh_pkg::MAX_HEIGHT))
            h_eff = ppbh_pkg::SZ_W'(ppbh_pkg::MAX_HEIGHT);
        else
            h_eff = ppbh_pkg::SZ_W'(cfg.height_px);

        cols = (ppbh_pkg::BC_W+1)'((w_eff + ppbh_pkg::SZ_W'(7)) >> 3);
    end

    // Scaling: exact 33-bit difference, its magnitude, one shared 32x32 multiply.
    always_comb
    begin
        diff_a   = (ctrl.op == ppbh_pkg::OP_DIFF_X) ? x_reg : y_reg;
        diff_o   = (ctrl.op == ppbh_pkg::OP_DIFF_X) ? cfg.x_origin : cfg.y_origin;
        diff     = {diff_a[31], diff_a} - {diff_o[31], diff_o};
        diff_abs = diff[32] ? (33'd0 - diff) : diff;
        gain_sel = (ctrl.op == ppbh_pkg::OP_MUL_X) ? cfg.x_gain : cfg.y_gain;
        product  = 64'(mag_reg) * 64'(gain_sel);
        sidx     = neg_reg ? (34'sd0 - $signed({2'b00, prod_reg}))
                           : $signed({2'b00, prod_reg});
    end

    // Dot pixel position, bounds check and byte address.
    always_comb
    begin
        px   = ix_reg + offset_value(ctrl.off_x);
        py   = iy_reg + offset_value(ctrl.off_y);
        in_x = !px[33] && (px[32:0] < 33'(w_eff));
        in_y = !py[33] && (py[32:0] < 33'(h_eff));
        pix_addr = ppbh_pkg::ADDR_W'(py[ppbh_pkg::ROW_W-1:0])
                   * ppbh_pkg::ADDR_W'(ppbh_pkg::STRIDE)
                   + ppbh_pkg::ADDR_W'(px[ppbh_pkg::BC_W+2:3]);
    end

    // Read position: fix-up before the read, byte flags, and the advance after it.
    always_comb
    begin
        col_over = ((ppbh_pkg::BC_W+1)'(rcol_reg) >= cols);
        row_inc  = (ppbh_pkg::ROW_W+1)'(rrow_reg) + (ppbh_pkg::ROW_W+1)'(col_over);
        fix_row  = (ppbh_pkg::SZ_W'(row_inc) >= h_eff) ? '0
                                                       : row_inc[ppbh_pkg::ROW_W-1:0];
        fix_col  = col_over ? '0 : rcol_reg;

        rd_addr = ppbh_pkg::ADDR_W'(rrow_reg) * ppbh_pkg::ADDR_W'(ppbh_pkg::STRIDE)
                  + ppbh_pkg::ADDR_W'(rcol_reg);

        inv = ~rd_reg;
        eor = ((ppbh_pkg::BC_W+1)'(rcol_reg) == (cols - 1'b1));
        eoi = eor && (ppbh_pkg::SZ_W'(rrow_reg) == (h_eff - 1'b1));

        col_adv  = (ppbh_pkg::BC_W+1)'(rcol_reg) + 1'b1;
        col_wrap = (col_adv >= cols);
        row_adv  = (ppbh_pkg::ROW_W+1)'(rrow_reg) + 1'b1;
        if (!col_wrap)
            adv_row = rrow_reg;
        else if (ppbh_pkg::SZ_W'(row_adv) >= h_eff)
            adv_row = '0;
        else
            adv_row = row_adv[ppbh_pkg::ROW_W-1:0];
        adv_col = col_wrap ? '0 : col_adv[ppbh_pkg::BC_W-1:0];
    end

    // Memory port selection: clearing or pixel write, pixel or raster read.
    always_comb
    begin
        mem_we    = (ctrl.op == ppbh_pkg::OP_CLEAR)
                    || ((ctrl.op == ppbh_pkg::OP_PIX_WR) && hit_reg);
        mem_waddr = (ctrl.op == ppbh_pkg::OP_CLEAR) ? clr_cnt_reg : addr_reg;
        mem_wdata = (ctrl.op == ppbh_pkg::OP_CLEAR) ? 8'h00 : (rd_reg | mask_reg);
        mem_re    = ((ctrl.op == ppbh_pkg::OP_PIX_RD) && in_x && in_y)
                    || (ctrl.op == ppbh_pkg::OP_RD_MEM);
        mem_raddr = (ctrl.op == ppbh_pkg::OP_RD_MEM) ? rd_addr : pix_addr;
    end

    assign clr_done = (clr_cnt_reg == ppbh_pkg::ADDR_W'(ppbh_pkg::DEPTH - 1));

    // Bitmap memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_reg <= mem[mem_raddr];
    end

    // Control state: clearing counter, read position and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            rrow_reg    <= '0;
            rcol_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (ctrl.op == ppbh_pkg::OP_RD_OUT);
            if (ctrl.op == ppbh_pkg::OP_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (ctrl.op == ppbh_pkg::OP_RD_FIX)
            begin
                rrow_reg <= fix_row;
                rcol_reg <= fix_col;
            end
            else if (ctrl.op == ppbh_pkg::OP_RD_OUT)
            begin
                rrow_reg <= adv_row;
                rcol_reg <= adv_col;
            end
        end
    end

    // Payload registers of the scaling and pixel steps, and the result fields.
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            ppbh_pkg::OP_IDLE:
            begin
                if (start)
                begin
                    x_reg <= x_coord;
                    y_reg <= y_coord;
                end
            end
            ppbh_pkg::OP_DIFF_X, ppbh_pkg::OP_DIFF_Y:
            begin
                mag_reg <= diff_abs[31:0];
                neg_reg <= diff[32];
            end
            ppbh_pkg::OP_MUL_X, ppbh_pkg::OP_MUL_Y:
                prod_reg <= product[63:32];
            ppbh_pkg::OP_SIGN_X:
                ix_reg <= sidx;
            ppbh_pkg::OP_SIGN_Y:
                iy_reg <= sidx;
            ppbh_pkg::OP_PIX_RD:
            begin
                addr_reg <= pix_addr;
                mask_reg <= 8'h80 >> px[2:0];
                hit_reg  <= in_x && in_y;
            end
            ppbh_pkg::OP_RD_OUT:
            begin
                hex_high_reg <= hex_digit(inv[7:4]);
                hex_low_reg  <= hex_digit(inv[3:0]);
                eor_reg      <= eor;
                eoi_reg      <= eoi;
            end
            default:
            begin
            end
        endcase
    end

    assign hex_high     = hex_high_reg;
    assign hex_low      = hex_low_reg;
    assign end_of_row   = eor_reg;
    assign end_of_image = eoi_reg;
    assign done         = done_reg;

endmodule

>>> rtl/core/point_plot_bitmap_hex_raster.sv
// Top level of the point plot bitmap hex raster block: configuration registers,
// microcode sequencer and datapath. Depends on ppbh_pkg, ppbh_sequencer, ppbh_datapath.

// After reset the block clears its bitmap store, one byte per cycle, all 524288 bytes
// (MAX_HEIGHT rows of MAX_WIDTH/8 bytes) with busy high; configuration writes are
// taken during that time. A transaction is accepted when start is high and busy is
// low. A plot transaction keeps busy high while six steps scale the point through
// one shared 32x32 multiplier and then each of the N pixels of the dot pattern (1, 2,
// 4 or 9) costs a read and a write of the bitmap memory. A read transaction keeps
// busy high through its fix-up, memory read and output steps; its result appears on
// hex_high, hex_low, end_of_row and end_of_image, marked by done high for exactly
// one cycle in the first cycle with busy low, and must be taken then. A plot
// transaction produces no result. Write configuration only while idle.

module point_plot_bitmap_hex_raster (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic               done,
    output logic [6:0]         hex_high,
    output logic [6:0]         hex_low,
    output logic               end_of_row,
    output logic               end_of_image,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [31:0]        wr_data
);

    ppbh_pkg::cfg_t  cfg_reg;
    ppbh_pkg::ctrl_t ctrl;
    logic            clr_done;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin  <= 32'sd0;
            cfg_reg.y_origin  <= 32'sd0;
            cfg_reg.x_gain    <= 32'h0001_0000;
            cfg_reg.y_gain    <= 32'h0001_0000;
            cfg_reg.width_px  <= 12'd1664;
            cfg_reg.height_px <= 12'd1664;
            cfg_reg.dot_size  <= ppbh_pkg::DOT_SINGLE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ppbh_pkg::CFG_X_ORIGIN:  cfg_reg.x_origin  <= $signed(wr_data);
                ppbh_pkg::CFG_Y_ORIGIN:  cfg_reg.y_origin  <= $signed(wr_data);
                ppbh_pkg::CFG_X_GAIN:    cfg_reg.x_gain    <= wr_data;
                ppbh_pkg::CFG_Y_GAIN:    cfg_reg.y_gain    <= wr_data;
                ppbh_pkg::CFG_WIDTH_PX:  cfg_reg.width_px  <= wr_data[11:0];
                ppbh_pkg::CFG_HEIGHT_PX: cfg_reg.height_px <= wr_data[11:0];
                ppbh_pkg::CFG_DOT_SIZE:  cfg_reg.dot_size  <= wr_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Microcode sequencer.
    ppbh_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .action   (action),
        .dot_size (cfg_reg.dot_size),
        .clr_done (clr_done),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    // Datapath and bitmap store.
    ppbh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .start        (start),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .cfg          (cfg_reg),
        .clr_done     (clr_done),
        .hex_high     (hex_high),
        .hex_low      (hex_low),
        .end_of_row   (end_of_row),
        .end_of_image (end_of_image),
        .done         (done)
    );

endmodule

>>> rtl/core/ppbh_checker.sv
// Port-level checker for the point plot bitmap hex raster block, bound to the top level.
// Depends only on the top level's port names.

module ppbh_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic action,
    input logic done
);

    // A result shows only while the block is idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // Each result is strobed for a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // An accepted transaction makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A read transaction delivers its result after its fix-up, memory read and output steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action) |-> ##1 !done ##1 !done ##1 !done ##1 done)
        else $error("read result missing or early");

    // A plot transaction produces no result during its first steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !action) |-> ##1 !done ##1 !done ##1 !done ##1 !done)
        else $error("plot transaction produced a result");

endmodule

bind point_plot_bitmap_hex_raster ppbh_checker u_ppbh_checker (.*);
